// File: rtl/core/fsmc_pkg.sv
package fsmc_pkg;

  localparam int DATA_DEPTH_DEF   = 16;
  localparam int RETURN_DEPTH_DEF = 16;
  localparam int CELL_BITS_DEF    = 32;
  localparam int FRAME_CELLS      = 3;
  localparam int MUL_CHUNK        = 16;
  localparam int TAP_COUNT        = 5;

  typedef enum logic [4:0] {
    CMD_LIT    = 5'd0,
    CMD_ADD    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_MUL    = 5'd3,
    CMD_DIV    = 5'd4,
    CMD_EQ     = 5'd5,
    CMD_NE     = 5'd6,
    CMD_LT     = 5'd7,
    CMD_LE     = 5'd8,
    CMD_GT     = 5'd9,
    CMD_GE     = 5'd10,
    CMD_MIN    = 5'd11,
    CMD_MAX    = 5'd12,
    CMD_DUP    = 5'd13,
    CMD_DROP   = 5'd14,
    CMD_SWAP   = 5'd15,
    CMD_OVER   = 5'd16,
    CMD_TO_R   = 5'd17,
    CMD_R_FROM = 5'd18,
    CMD_I      = 5'd19,
    CMD_J      = 5'd20,
    CMD_UNLOOP = 5'd21
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_DUNDER  = 3'd1,
    STAT_DOVER   = 3'd2,
    STAT_DIVZERO = 3'd3,
    STAT_RUNDER  = 3'd4,
    STAT_ROVER   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    SO_HOLD,
    SO_PUSH,
    SO_POP,
    SO_POP3,
    SO_REPLACE,
    SO_SWAP
  } stk_op_t;

  typedef enum logic [2:0] {
    CS_HOLD,
    CS_UP,
    CS_DOWN,
    CS_DOWN3,
    CS_LOAD
  } cell_sel_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } arith_ctl_t;

  typedef struct packed {
    logic [2:0] dneed;
    logic [2:0] rneed;
    logic       dgrow;
    logic       rgrow;
  } need_t;

  typedef struct packed {
    logic        [4:0]  command;
    logic signed [31:0] literal_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic        [4:0]  data_depth;
    logic        [4:0]  return_depth;
    logic        [2:0]  status;
  } out_rsp_t;

  function automatic need_t cmd_need(logic [4:0] cmd);
    need_t n;
    n = '0;
    case (cmd) inside
      [CMD_ADD:CMD_MAX]: n.dneed = 3'd2;
      CMD_LIT:    n.dgrow = 1'b1;
      CMD_DUP:    begin n.dneed = 3'd1; n.dgrow = 1'b1; end
      CMD_DROP:   n.dneed = 3'd1;
      CMD_SWAP:   n.dneed = 3'd2;
      CMD_OVER:   begin n.dneed = 3'd2; n.dgrow = 1'b1; end
      CMD_TO_R:   begin n.dneed = 3'd1; n.rgrow = 1'b1; end
      CMD_R_FROM: begin n.rneed = 3'd1; n.dgrow = 1'b1; end
      CMD_I:      begin n.rneed = 3'd2; n.dgrow = 1'b1; end
      CMD_J:      begin n.rneed = 3'd5; n.dgrow = 1'b1; end
      CMD_UNLOOP: n.rneed = 3'(FRAME_CELLS);
      default:    n = '0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/fsmc_cell.sv
module fsmc_cell import fsmc_pkg::*; #(
  parameter int W = CELL_BITS_DEF
) (
  input  logic         clk,
  input  cell_sel_t    sel_i,
  input  logic [W-1:0] up_i,
  input  logic [W-1:0] dn_i,
  input  logic [W-1:0] dn3_i,
  input  logic [W-1:0] ld_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    case (sel_i)
      CS_UP:    q_nxt = up_i;
      CS_DOWN:  q_nxt = dn_i;
      CS_DOWN3: q_nxt = dn3_i;
      CS_LOAD:  q_nxt = ld_i;
      default:  q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// File: rtl/core/fsmc_stack.sv
module fsmc_stack import fsmc_pkg::*; #(
  parameter int DEPTH = DATA_DEPTH_DEF,
  parameter int W     = CELL_BITS_DEF
) (
  input  logic         clk,
  input  stk_op_t      op_i,
  input  logic [W-1:0] wdata_i,
  output logic [W-1:0] tap_o [TAP_COUNT]
);

  logic [W-1:0] val  [DEPTH];
  cell_sel_t    sel  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] up_v;
    logic [W-1:0] dn_v;
    logic [W-1:0] dn3_v;
    logic [W-1:0] ld_v;

    if (k == 0) begin : g_up_top
      assign up_v = wdata_i;
    end else begin : g_up_mid
      assign up_v = val[k-1];
    end

    if (k + 1 < DEPTH) begin : g_dn
      assign dn_v = val[k+1];
    end else begin : g_dn_end
      assign dn_v = '0;
    end

    if (k + 3 < DEPTH) begin : g_dn3
      assign dn3_v = val[k+3];
    end else begin : g_dn3_end
      assign dn3_v = '0;
    end

    if (k == 1) begin : g_ld_swap
      assign ld_v = val[0];
    end else begin : g_ld
      assign ld_v = wdata_i;
    end

    always_comb begin
      unique case (op_i)
        SO_HOLD:    sel[k] = CS_HOLD;
        SO_PUSH:    sel[k] = CS_UP;
        SO_POP:     sel[k] = CS_DOWN;
        SO_POP3:    sel[k] = CS_DOWN3;
        SO_REPLACE: sel[k] = (k == 0) ? CS_LOAD : CS_DOWN;
        SO_SWAP:    sel[k] = (k < 2) ? CS_LOAD : CS_HOLD;
        default:    sel[k] = CS_HOLD;
      endcase
    end

    fsmc_cell #(.W(W)) u_cell (
      .clk   (clk),
      .sel_i (sel[k]),
      .up_i  (up_v),
      .dn_i  (dn_v),
      .dn3_i (dn3_v),
      .ld_i  (ld_v),
      .q_o   (val[k])
    );
  end

  for (genvar t = 0; t < TAP_COUNT; t++) begin : g_tap
    if (t < DEPTH) begin : g_live
      assign tap_o[t] = val[t];
    end else begin : g_none
      assign tap_o[t] = '0;
    end
  end

endmodule

// File: rtl/core/fsmc_arith.sv
module fsmc_arith import fsmc_pkg::*; #(
  parameter int CELL_BITS = CELL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arith_ctl_t           ctl_i,
  input  logic [CELL_BITS-1:0] a_i,
  input  logic [CELL_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [CELL_BITS-1:0] result_o
);

  localparam int CW        = CELL_BITS;
  localparam int MUL_STEPS = (CW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int CNTW      = $clog2(CW + 1);

  logic            busy_r, busy_nxt;
  logic            div_r, div_nxt;
  logic            neg_r, neg_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   x_r, x_nxt;
  logic [CW-1:0]   y_r, y_nxt;
  logic [CW-1:0]   z_r, z_nxt;

  logic [CW-1:0]           mag_a, mag_b;
  logic [CW+MUL_CHUNK-1:0] prod;
  logic [CW:0]             sh, trial;

  // x: multiplicand / dividend-quotient, y: multiplier / divisor, z: acc / remainder
  assign mag_a = a_i[CW-1] ? -a_i : a_i;
  assign mag_b = b_i[CW-1] ? -b_i : b_i;
  assign prod  = x_r * y_r[MUL_CHUNK-1:0];
  assign sh    = {z_r, x_r[CW-1]};
  assign trial = sh - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (ctl_i.start) begin
      busy_nxt = 1'b1;
      div_nxt  = ctl_i.is_div;
      z_nxt    = '0;
      if (ctl_i.is_div) begin
        cnt_nxt = CNTW'(CW);
        x_nxt   = mag_a;
        y_nxt   = mag_b;
        neg_nxt = a_i[CW-1] ^ b_i[CW-1];
      end else begin
        cnt_nxt = CNTW'(MUL_STEPS);
        x_nxt   = a_i;
        y_nxt   = b_i;
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (div_r) begin
          x_nxt = {x_r[CW-2:0], ~trial[CW]};
          z_nxt = trial[CW] ? sh[CW-1:0] : trial[CW-1:0];
        end else begin
          z_nxt = z_r + prod[CW-1:0];
          x_nxt = x_r << MUL_CHUNK;
          y_nxt = y_r >> MUL_CHUNK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign done_o   = busy_r && (cnt_r == '0);
  assign result_o = div_r ? (neg_r ? -x_r : x_r) : z_r;

endmodule

// File: rtl/core/forth_stack_machine_core.sv
// Dual-stack machine core: one stack opcode per request on a data stack and a
// return stack, each a chain of shift cells whose top entries are read at fixed
// taps. A request is accepted when idle; unless it starts a multiply or divide,
// its response is shown the next cycle. Only one request is in flight: a new one
// is taken only after the last response is taken. Multiply runs through the
// shared iterative unit at 16 multiplier bits a step; divide retires one quotient
// bit a step. A fault (underflow, overflow, divide by zero) leaves both stacks
// untouched and is reported in status. Stack contents are not cleared at reset;
// only the depths are.
module forth_stack_machine_core import fsmc_pkg::*; #(
  parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
  parameter int CELL_BITS    = CELL_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  localparam int CW  = CELL_BITS;
  localparam int DPW = $clog2(DATA_DEPTH + 1);
  localparam int RPW = $clog2(RETURN_DEPTH + 1);

  state_t         state_r, state_nxt;
  logic [DPW-1:0] dp_r, dp_nxt;
  logic [RPW-1:0] rp_r, rp_nxt;
  status_t        status_r, status_nxt;

  logic [CW-1:0] dtap [TAP_COUNT];
  logic [CW-1:0] rtap [TAP_COUNT];
  logic [CW-1:0] a_v, b_v;

  stk_op_t       dop, rop, dec_dop, dec_rop;
  logic [CW-1:0] dwd, rwd, dec_dwd, dec_rwd;

  need_t         nd;
  status_t       fault;
  logic          legal, exec, use_arith;
  logic          dec_dinc, dec_ddec, dec_rinc, dec_rdec, dec_rdec3;
  logic          accept;

  arith_ctl_t    actl;
  logic          arith_done;
  logic [CW-1:0] arith_res;

  logic [CW+31:0]  lit_ext;
  logic [CW-1:0]   lit_cell;
  logic [CW+31:0]  top_ext;
  logic [DPW+4:0]  dp_ext;
  logic [RPW+4:0]  rp_ext;
  logic            lt_ab, lt_ba;

  assign a_v      = dtap[1];
  assign b_v      = dtap[0];
  assign lit_ext  = {{CW{in_req.literal_value[31]}}, in_req.literal_value};
  assign lit_cell = lit_ext[CW-1:0];
  assign lt_ab    = $signed(a_v) < $signed(b_v);
  assign lt_ba    = $signed(b_v) < $signed(a_v);
  assign accept   = in_valid && in_ready;

  // fault checks in priority order
  always_comb begin
    nd    = cmd_need(in_req.command);
    legal = in_req.command <= CMD_UNLOOP;
    fault = STAT_OK;
    if (!legal) begin
      fault = STAT_OK;
    end else if (dp_r < DPW'(nd.dneed)) begin
      fault = STAT_DUNDER;
    end else if (rp_r < RPW'(nd.rneed)) begin
      fault = STAT_RUNDER;
    end else if (nd.dgrow && (dp_r >= DPW'(DATA_DEPTH))) begin
      fault = STAT_DOVER;
    end else if (nd.rgrow && (rp_r >= RPW'(RETURN_DEPTH))) begin
      fault = STAT_ROVER;
    end else if ((in_req.command == CMD_DIV) && (b_v == '0)) begin
      fault = STAT_DIVZERO;
    end
    exec = legal && (fault == STAT_OK);
  end

  always_comb begin
    dec_dop   = SO_HOLD;
    dec_rop   = SO_HOLD;
    dec_dwd   = '0;
    dec_rwd   = '0;
    dec_dinc  = 1'b0;
    dec_ddec  = 1'b0;
    dec_rinc  = 1'b0;
    dec_rdec  = 1'b0;
    dec_rdec3 = 1'b0;
    use_arith = 1'b0;
    case (in_req.command) inside
      CMD_LIT: begin dec_dop = SO_PUSH; dec_dwd = lit_cell; dec_dinc = 1'b1; end
      CMD_ADD: begin dec_dop = SO_REPLACE; dec_dwd = a_v + b_v; dec_ddec = 1'b1; end
      CMD_SUB: begin dec_dop = SO_REPLACE; dec_dwd = a_v - b_v; dec_ddec = 1'b1; end
      CMD_MUL, CMD_DIV: use_arith = 1'b1;
      [CMD_EQ:CMD_MAX]: begin
        dec_dop  = SO_REPLACE;
        dec_ddec = 1'b1;
        case (in_req.command)
          CMD_EQ:  dec_dwd = (a_v == b_v) ? '1 : '0;
          CMD_NE:  dec_dwd = (a_v != b_v) ? '1 : '0;
          CMD_LT:  dec_dwd = lt_ab ? '1 : '0;
          CMD_LE:  dec_dwd = !lt_ba ? '1 : '0;
          CMD_GT:  dec_dwd = lt_ba ? '1 : '0;
          CMD_GE:  dec_dwd = !lt_ab ? '1 : '0;
          CMD_MIN: dec_dwd = lt_ba ? b_v : a_v;
          default: dec_dwd = lt_ab ? b_v : a_v;
        endcase
      end
      CMD_DUP:  begin dec_dop = SO_PUSH; dec_dwd = b_v; dec_dinc = 1'b1; end
      CMD_DROP: begin dec_dop = SO_POP; dec_ddec = 1'b1; end
      CMD_SWAP: begin dec_dop = SO_SWAP; dec_dwd = a_v; end
      CMD_OVER: begin dec_dop = SO_PUSH; dec_dwd = a_v; dec_dinc = 1'b1; end
      CMD_TO_R: begin
        dec_dop  = SO_POP;
        dec_ddec = 1'b1;
        dec_rop  = SO_PUSH;
        dec_rwd  = b_v;
        dec_rinc = 1'b1;
      end
      CMD_R_FROM: begin
        dec_dop  = SO_PUSH;
        dec_dwd  = rtap[0];
        dec_dinc = 1'b1;
        dec_rop  = SO_POP;
        dec_rdec = 1'b1;
      end
      CMD_I:      begin dec_dop = SO_PUSH; dec_dwd = rtap[1]; dec_dinc = 1'b1; end
      CMD_J:      begin dec_dop = SO_PUSH; dec_dwd = rtap[4]; dec_dinc = 1'b1; end
      CMD_UNLOOP: begin dec_rop = SO_POP3; dec_rdec3 = 1'b1; end
      default:    use_arith = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = (exec && use_arith) ? S_CALC : S_RESP;
      S_CALC: if (arith_done) state_nxt = S_RESP;
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and stack control
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    dop        = SO_HOLD;
    rop        = SO_HOLD;
    dwd        = dec_dwd;
    rwd        = dec_rwd;
    dp_nxt     = dp_r;
    rp_nxt     = rp_r;
    status_nxt = status_r;
    actl       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt  = fault;
          actl.start  = exec && use_arith;
          actl.is_div = in_req.command == CMD_DIV;
          if (exec && !use_arith) begin
            dop = dec_dop;
            rop = dec_rop;
            if (dec_dinc) dp_nxt = dp_r + 1'b1;
            if (dec_ddec) dp_nxt = dp_r - 1'b1;
            if (dec_rinc) rp_nxt = rp_r + 1'b1;
            if (dec_rdec) rp_nxt = rp_r - 1'b1;
            if (dec_rdec3) rp_nxt = rp_r - RPW'(FRAME_CELLS);
          end
        end
      end
      S_CALC: begin
        if (arith_done) begin
          dop    = SO_REPLACE;
          dwd    = arith_res;
          dp_nxt = dp_r - 1'b1;
        end
      end
      S_RESP: out_valid = 1'b1;
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dp_r     <= '0;
      rp_r     <= '0;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      dp_r     <= dp_nxt;
      rp_r     <= rp_nxt;
      status_r <= status_nxt;
    end
  end

  fsmc_stack #(.DEPTH(DATA_DEPTH), .W(CW)) u_dstack (
    .clk     (clk),
    .op_i    (dop),
    .wdata_i (dwd),
    .tap_o   (dtap)
  );

  fsmc_stack #(.DEPTH(RETURN_DEPTH), .W(CW)) u_rstack (
    .clk     (clk),
    .op_i    (rop),
    .wdata_i (rwd),
    .tap_o   (rtap)
  );

  fsmc_arith #(.CELL_BITS(CW)) u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (actl),
    .a_i      (a_v),
    .b_i      (b_v),
    .done_o   (arith_done),
    .result_o (arith_res)
  );

  assign top_ext = {32'b0, dtap[0]};
  assign dp_ext  = {5'b0, dp_r};
  assign rp_ext  = {5'b0, rp_r};

  assign out_rsp.top_value    = (dp_r == '0) ? '0 : top_ext[31:0];
  assign out_rsp.data_depth   = dp_ext[4:0];
  assign out_rsp.return_depth = rp_ext[4:0];
  assign out_rsp.status       = status_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_r <= DPW'(DATA_DEPTH)) && (rp_r <= RPW'(RETURN_DEPTH)))
    else $error("stack depth beyond capacity");

  a_fault_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (fault != STAT_OK)) |=> ($stable(dp_r) && $stable(rp_r)))
    else $error("faulting request changed a depth");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> (state_r == S_CALC))
    else $error("arith completion outside calc state");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while response pending");
`endif

endmodule

// File: tb/tb_forth_stack_machine_core.sv
module tb_forth_stack_machine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fsmc_pkg::*;

  localparam int DSTK = DATA_DEPTH_DEF;
  localparam int RSTK = RETURN_DEPTH_DEF;
  localparam int DIRECTED_OPS = 25;
  localparam int RANDOM_OPS = 400;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [DSTK-1:0][31:0] ds;
    logic [RSTK-1:0][31:0] rs;
    logic [4:0]            dp;
    logic [4:0]            rp;
  } machine_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  in_req_t  op_queue[$];
  out_rsp_t expected_rsp[$];
  machine_t core_state = '0;
  machine_t plan_state = '0;

  int planned = 0;
  int rsp_count = 0;
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  forth_stack_machine_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic exec_op(input machine_t m, input in_req_t r, output machine_t nm,
                         output out_rsp_t rsp);
    int dneed, rneed, dp, rp;
    logic dgrow, rgrow, binop;
    status_t st;
    logic signed [31:0] a, b, res;
    logic [31:0] ma, mb, q;
    nm = m;
    dneed = 0;
    rneed = 0;
    dgrow = 1'b0;
    rgrow = 1'b0;
    binop = 1'b0;
    st = STAT_OK;
    res = '0;
    dp = m.dp;
    rp = m.rp;
    case (r.command)
      CMD_LIT: dgrow = 1'b1;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_NE, CMD_LT, CMD_LE, CMD_GT, CMD_GE,
      CMD_MIN, CMD_MAX: begin
        dneed = 2;
        binop = 1'b1;
      end
      CMD_DUP: begin
        dneed = 1;
        dgrow = 1'b1;
      end
      CMD_DROP: dneed = 1;
      CMD_SWAP: dneed = 2;
      CMD_OVER: begin
        dneed = 2;
        dgrow = 1'b1;
      end
      CMD_TO_R: begin
        dneed = 1;
        rgrow = 1'b1;
      end
      CMD_R_FROM: begin
        rneed = 1;
        dgrow = 1'b1;
      end
      CMD_I: begin
        rneed = 2;
        dgrow = 1'b1;
      end
      CMD_J: begin
        rneed = 5;
        dgrow = 1'b1;
      end
      CMD_UNLOOP: rneed = FRAME_CELLS;
      default: ;
    endcase

    if (dp < dneed) st = STAT_DUNDER;
    else if (rp < rneed) st = STAT_RUNDER;
    else if (dgrow && dp >= DSTK) st = STAT_DOVER;
    else if (rgrow && rp >= RSTK) st = STAT_ROVER;
    else if (r.command == CMD_DIV && m.ds[dp-1] == '0) st = STAT_DIVZERO;

    if (st == STAT_OK) begin
      a = (dp >= 2) ? m.ds[dp-2] : '0;
      b = (dp >= 1) ? m.ds[dp-1] : '0;
      case (r.command)
        CMD_LIT: begin
          nm.ds[dp] = r.literal_value;
          dp++;
        end
        CMD_ADD: res = a + b;
        CMD_SUB: res = a - b;
        CMD_MUL: res = a * b;
        CMD_DIV: begin
          ma = a[31] ? (~a + 32'd1) : a;
          mb = b[31] ? (~b + 32'd1) : b;
          q = ma / mb;
          res = (a[31] ^ b[31]) ? (~q + 32'd1) : q;
        end
        CMD_EQ: res = (a == b) ? '1 : '0;
        CMD_NE: res = (a != b) ? '1 : '0;
        CMD_LT: res = (a < b) ? '1 : '0;
        CMD_LE: res = (a <= b) ? '1 : '0;
        CMD_GT: res = (a > b) ? '1 : '0;
        CMD_GE: res = (a >= b) ? '1 : '0;
        CMD_MIN: res = (b < a) ? b : a;
        CMD_MAX: res = (a < b) ? b : a;
        CMD_DUP: begin
          nm.ds[dp] = b;
          dp++;
        end
        CMD_DROP: dp--;
        CMD_SWAP: begin
          nm.ds[dp-2] = b;
          nm.ds[dp-1] = a;
        end
        CMD_OVER: begin
          nm.ds[dp] = a;
          dp++;
        end
        CMD_TO_R: begin
          nm.rs[rp] = b;
          rp++;
          dp--;
        end
        CMD_R_FROM: begin
          nm.ds[dp] = m.rs[rp-1];
          dp++;
          rp--;
        end
        CMD_I: begin
          nm.ds[dp] = m.rs[rp-2];
          dp++;
        end
        CMD_J: begin
          nm.ds[dp] = m.rs[rp-5];
          dp++;
        end
        CMD_UNLOOP: rp -= FRAME_CELLS;
        default: ;
      endcase
      if (binop) begin
        nm.ds[dp-2] = res;
        dp--;
      end
      nm.dp = 5'(dp);
      nm.rp = 5'(rp);
    end

    rsp.top_value = (nm.dp != 0) ? nm.ds[nm.dp-1] : '0;
    rsp.data_depth = nm.dp;
    rsp.return_depth = nm.rp;
    rsp.status = st;
  endtask

  function automatic logic [31:0] pick_literal();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [4:0] c, input logic [31:0] v);
    in_req_t r;
    out_rsp_t unused_rsp;
    r.command = c;
    r.literal_value = v;
    op_queue.push_back(r);
    exec_op(plan_state, r, plan_state, unused_rsp);
    planned++;
  endtask

  // request driver
  always @(posedge clk) begin
    out_rsp_t predicted;
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        exec_op(core_state, in_req, core_state, predicted);
        expected_rsp.push_back(predicted);
        void'(op_queue.pop_front());
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_req <= op_queue[0];
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20)
                                                   : $urandom_range(0, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && rsp_count >= 150) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 100);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      rsp_count++;
      if (expected_rsp.size() == 0) begin
        if (mismatches < 10)
          $display("MISMATCH: response with no request pending: top=%0d dd=%0d rd=%0d st=%0d",
                   out_rsp.top_value, out_rsp.data_depth, out_rsp.return_depth,
                   out_rsp.status);
        mismatches++;
      end else begin
        want = expected_rsp.pop_front();
        if (out_rsp.top_value !== want.top_value || out_rsp.data_depth !== want.data_depth ||
            out_rsp.return_depth !== want.return_depth || out_rsp.status !== want.status) begin
          if (mismatches < 10)
            $display({"MISMATCH at response %0d: expected top=%0d dd=%0d rd=%0d st=%0d,",
                      " got top=%0d dd=%0d rd=%0d st=%0d"}, rsp_count,
                     want.top_value, want.data_depth, want.return_depth, want.status,
                     out_rsp.top_value, out_rsp.data_depth, out_rsp.return_depth,
                     out_rsp.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int pick, k;
    bit found;
    in_req_t trial;
    machine_t scratch;
    out_rsp_t trial_rsp;

    // underflow on empty stacks, unused opcodes, wrap and divide corners
    queue_op(CMD_DROP, 32'h0);
    queue_op(CMD_R_FROM, 32'hffff_ffff);
    queue_op(5'd31, 32'hffff_ffff);
    queue_op(CMD_LIT, 32'h7fff_ffff);
    queue_op(CMD_LIT, 32'h0000_0001);
    queue_op(CMD_ADD, 32'h0);
    queue_op(CMD_LIT, 32'hffff_ffff);
    queue_op(CMD_DIV, 32'h0);
    queue_op(CMD_LIT, 32'h0);
    queue_op(CMD_DIV, 32'h0);
    queue_op(CMD_MUL, 32'h0);
    queue_op(CMD_LIT, -32'sd7);
    queue_op(CMD_LIT, 32'd2);
    queue_op(CMD_DIV, 32'h0);
    queue_op(CMD_OVER, 32'h0);
    queue_op(CMD_SWAP, 32'h0);
    queue_op(CMD_LT, 32'h0);
    queue_op(CMD_TO_R, 32'h0);
    queue_op(CMD_TO_R, 32'h0);
    queue_op(CMD_TO_R, 32'h0);
    queue_op(CMD_I, 32'h0);
    queue_op(CMD_J, 32'h0);
    queue_op(CMD_UNLOOP, 32'h0);
    queue_op(CMD_UNLOOP, 32'h0);
    queue_op(5'd22, 32'h0);

    while (planned < DIRECTED_OPS + RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        while (plan_state.dp < DSTK) queue_op(CMD_LIT, pick_literal());
        queue_op(CMD_LIT, pick_literal());
      end else if (pick < 5) begin
        while (plan_state.rp < RSTK) begin
          if (plan_state.dp == 0) queue_op(CMD_LIT, pick_literal());
          queue_op(CMD_TO_R, $urandom);
        end
        if (plan_state.dp == 0) queue_op(CMD_LIT, pick_literal());
        queue_op(CMD_TO_R, $urandom);
      end else if (pick < 10 && plan_state.rp <= RSTK - FRAME_CELLS) begin
        // loop frame: push a frame, read the indices, unloop
        repeat (FRAME_CELLS) begin
          if (plan_state.dp == 0) queue_op(CMD_LIT, pick_literal());
          queue_op(CMD_TO_R, $urandom);
        end
        queue_op(CMD_I, $urandom);
        if ($urandom_range(0, 1) == 1) queue_op(CMD_J, $urandom);
        queue_op(CMD_UNLOOP, $urandom);
      end else if (pick < 22) begin
        queue_op(5'($urandom_range(0, 31)), $urandom);
      end else begin
        found = 1'b0;
        for (k = 0; k < 8 && !found; k++) begin
          trial.command = 5'($urandom_range(0, 21));
          trial.literal_value = (trial.command == CMD_LIT) ? pick_literal() : $urandom;
          exec_op(plan_state, trial, scratch, trial_rsp);
          if (trial_rsp.status == STAT_OK || trial_rsp.status == STAT_DIVZERO) found = 1'b1;
        end
        if (found) queue_op(trial.command, trial.literal_value);
        else queue_op(CMD_LIT, pick_literal());
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: %0d requests still queued, %0d responses outstanding",
             op_queue.size(), expected_rsp.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
